// File: design/alag_pkg.sv
package alag_pkg;

  // Input and result field widths.
  localparam int DEGREE_W = 4;
  localparam int ORDER_W  = 5;
  localparam int POINT_W  = 40;
  localparam int DATA_W   = 64;
  localparam int PROD_W   = 2 * DATA_W;

  // Input stream payload: degree, order and point packed and padded to whole bytes.
  localparam int S_TDATA_W = ((DEGREE_W + ORDER_W + POINT_W + 7) / 8) * 8;
  localparam int DEGREE_LSB = 0;
  localparam int ORDER_LSB  = DEGREE_LSB + DEGREE_W;
  localparam int POINT_LSB  = ORDER_LSB + ORDER_W;

  // The multiplier takes one 16-bit digit of the wide operand per cycle.
  localparam int DIGIT_W = 16;
  localparam int DIGITS  = DATA_W / DIGIT_W;

  // The divider retires eight quotient bits per cycle.
  localparam int DIV_RADIX_BITS = 8;
  localparam int DIV_CYCLES     = DATA_W / DIV_RADIX_BITS;

  localparam int DEF_MAX_DEGREE = 15;
  localparam int DEF_FRAC_BITS  = 24;

  typedef struct packed {
    logic load;       // capture a new item and set up L0 and L1
    logic deg_zero;   // the new item has degree zero
    logic mul_start;  // load multiplier operands
    logic mul_step;   // multiply-accumulate one digit
    logic mul_end;    // scale, saturate and store a product
    logic sel;        // 0: coefficient a times L_j, 1: coefficient b times L_j-1
    logic sub;        // saturating difference of the two products
    logic div_step;   // one radix-256 step of the division
    logic advance;    // shift the recurrence by one degree
    logic out_load;   // move the result to the output register
  } alag_cmd_t;

endpackage

// File: design/associated_laguerre_eval_unit.sv
// Evaluates the associated Laguerre polynomial L_n^k(x) by the three-term
// recurrence, with x in signed Q15.24 and the result in signed Q39.24
// (FRAC_BITS fractional bits). Degrees above MAX_DEGREE are clamped. Each
// product is scaled by an arithmetic right shift, and any product or
// difference outside the 64-bit range saturates and raises the overflow flag
// for that result. The unit works on one item at a time. Every recurrence
// step runs two products through one shared 64x16 multiplier, four digits
// each, and a divide by j+1 that retires eight quotient bits per cycle. The
// result sits in an output register, so a new item is taken while the last
// result is still waiting.
module associated_laguerre_eval_unit import alag_pkg::*; #(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // degree[3:0], order[8:4], point[48:9], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // value[63:0]
  output logic                 m_tuser    // overflow[0]
);

  localparam int JW = $clog2(MAX_DEGREE + 1);

  alag_cmd_t                cmd;
  logic [JW-1:0]            step;
  logic signed [DATA_W-1:0] value;

  alag_ctrl #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .degree   (s_tdata[DEGREE_LSB +: DEGREE_W]),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd      (cmd),
    .step     (step)
  );

  alag_dp #(
    .MAX_DEGREE(MAX_DEGREE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .step    (step),
    .order   (s_tdata[ORDER_LSB +: ORDER_W]),
    .point   (s_tdata[POINT_LSB +: POINT_W]),
    .value   (value),
    .overflow(m_tuser)
  );

  assign m_tdata = value;

`ifndef SYNTHESIS
  // An accepted item always leaves the unit busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again right after a transfer");

  // A new result is only produced from a busy state.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while the unit was idle");
`endif

endmodule

// File: design/alag_ctrl.sv
module alag_ctrl import alag_pkg::*; #(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE,
  localparam int JW = $clog2(MAX_DEGREE + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DEGREE_W-1:0] degree,
  output logic                out_valid,
  input  logic                out_ready,
  output alag_cmd_t           cmd,
  output logic [JW-1:0]       step
);

  localparam int CNT_W = $clog2((DIV_CYCLES > DIGITS) ? DIV_CYCLES : DIGITS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MSTEP  = 3'd2;
  localparam logic [2:0] S_MEND   = 3'd3;
  localparam logic [2:0] S_SUB    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_NEXT   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]       state, state_next;
  logic [JW-1:0]    n, n_next;
  logic [JW-1:0]    j, j_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             sel, sel_next;
  logic             valid, valid_next;
  logic [JW-1:0]    n_clamp;
  logic [JW-1:0]    j_inc;

  // Degrees above the supported maximum are clamped.
  assign n_clamp = (int'(degree) > MAX_DEGREE) ? JW'(MAX_DEGREE) : JW'(degree);
  assign j_inc   = JW'(j + 1'b1);

  always_comb begin
    state_next = state;
    n_next     = n;
    j_next     = j;
    cnt_next   = cnt;
    sel_next   = sel;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.deg_zero = (degree == '0);
          n_next       = n_clamp;
          j_next       = JW'(1);
          sel_next     = 1'b0;
          state_next   = (n_clamp <= JW'(1)) ? S_DONE : S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        cmd.sel       = sel;
        cnt_next      = '0;
        state_next    = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIGITS - 1)) begin
          state_next = S_MEND;
        end
      end
      S_MEND: begin
        cmd.mul_end = 1'b1;
        cmd.sel     = sel;
        if (!sel) begin
          sel_next   = 1'b1;
          state_next = S_MSTART;
        end else begin
          state_next = S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.advance = 1'b1;
        j_next      = j_inc;
        sel_next    = 1'b0;
        state_next  = (j_inc == n) ? S_DONE : S_MSTART;
      end
      S_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_next = valid;
    if (cmd.out_load) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      j     <= '0;
      cnt   <= '0;
      sel   <= 1'b0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      j     <= j_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
      valid <= valid_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = valid;
  assign step      = j;

endmodule

// File: design/alag_dp.sv
module alag_dp import alag_pkg::*; #(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  localparam int JW = $clog2(MAX_DEGREE + 1)
) (
  input  logic                      clk,
  input  alag_cmd_t                 cmd,
  input  logic [JW-1:0]             step,
  input  logic [ORDER_W-1:0]        order,
  input  logic signed [POINT_W-1:0] point,
  output logic signed [DATA_W-1:0]  value,
  output logic                      overflow
);

  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W - 1){1'b0}}};

  logic signed [POINT_W-1:0] x;
  logic [ORDER_W-1:0]        k;
  logic signed [DATA_W-1:0]  prev, curr, p1, p2;
  logic [DATA_W-1:0]         mag_a, mag_b;
  logic                      neg;
  logic [PROD_W-1:0]         acc;
  logic [DATA_W-1:0]         dvd;
  logic [JW-1:0]             rem;
  logic                      dneg;
  logic                      ovf;

  logic signed [DATA_W-1:0]  one, x_ext, pt_ext, curr0, ca, cb, op_a, op_b;
  logic [DATA_W-1:0]         coef_a;
  logic [DATA_W+DIGIT_W-1:0] pp;
  logic signed [PROD_W-1:0]  prod_s, sh;
  logic                      mul_sat;
  logic signed [DATA_W-1:0]  mul_res;
  logic signed [DATA_W:0]    diff;
  logic                      sub_sat;
  logic signed [DATA_W-1:0]  dres;
  logic [JW-1:0]             dv;
  logic [DATA_W-1:0]         ds;
  logic [JW-1:0]             dr;
  logic [JW:0]               trial;

  assign one    = signed'(DATA_W'(1) << FRAC_BITS);
  assign x_ext  = DATA_W'(x);
  assign pt_ext = DATA_W'(point);
  assign curr0  = signed'((DATA_W'(order) + DATA_W'(1)) << FRAC_BITS) - pt_ext;

  // Recurrence coefficients: a = 2j+k+1-x and b = j+k.
  assign coef_a = (DATA_W'(step) << 1) + DATA_W'(k) + DATA_W'(1);
  assign ca     = signed'(coef_a << FRAC_BITS) - x_ext;
  assign cb     = signed'((DATA_W'(step) + DATA_W'(k)) << FRAC_BITS);
  assign op_a   = cmd.sel ? cb : ca;
  assign op_b   = cmd.sel ? prev : curr;

  // Digits of the second operand enter most significant first.
  assign pp = mag_a * mag_b[DATA_W-1 -: DIGIT_W];

  always_comb begin
    prod_s  = neg ? signed'(-acc) : signed'(acc);
    sh      = prod_s >>> FRAC_BITS;
    mul_sat = (sh[PROD_W-1:DATA_W-1] != {(PROD_W - DATA_W + 1){sh[DATA_W-1]}});
    if (mul_sat) begin
      mul_res = sh[PROD_W-1] ? MIN_VAL : MAX_VAL;
    end else begin
      mul_res = sh[DATA_W-1:0];
    end
  end

  always_comb begin
    diff    = {p1[DATA_W-1], p1} - {p2[DATA_W-1], p2};
    sub_sat = (diff[DATA_W] != diff[DATA_W-1]);
    if (sub_sat) begin
      dres = p1[DATA_W-1] ? MIN_VAL : MAX_VAL;
    end else begin
      dres = diff[DATA_W-1:0];
    end
  end

  // Restoring division of the magnitude by j+1, eight bits per cycle.
  // The quotient bits shift in behind the dividend bits.
  assign dv = JW'(step + 1'b1);

  always_comb begin
    ds    = dvd;
    dr    = rem;
    trial = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial = {dr, ds[DATA_W-1]};
      ds    = ds << 1;
      if (trial >= {1'b0, dv}) begin
        dr    = JW'(trial - {1'b0, dv});
        ds[0] = 1'b1;
      end else begin
        dr = trial[JW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= point;
      k    <= order;
      prev <= one;
      curr <= cmd.deg_zero ? one : curr0;
      ovf  <= 1'b0;
    end
    if (cmd.mul_start) begin
      mag_a <= op_a[DATA_W-1] ? DATA_W'(-op_a) : DATA_W'(op_a);
      mag_b <= op_b[DATA_W-1] ? DATA_W'(-op_b) : DATA_W'(op_b);
      neg   <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
      acc   <= '0;
    end
    if (cmd.mul_step) begin
      acc   <= (acc << DIGIT_W) + PROD_W'(pp);
      mag_b <= mag_b << DIGIT_W;
    end
    if (cmd.mul_end) begin
      if (cmd.sel) begin
        p2 <= mul_res;
      end else begin
        p1 <= mul_res;
      end
      ovf <= ovf | mul_sat;
    end
    if (cmd.sub) begin
      dvd  <= dres[DATA_W-1] ? DATA_W'(-dres) : DATA_W'(dres);
      dneg <= dres[DATA_W-1];
      rem  <= '0;
      ovf  <= ovf | sub_sat;
    end
    if (cmd.div_step) begin
      dvd <= ds;
      rem <= dr;
    end
    if (cmd.advance) begin
      prev <= curr;
      curr <= dneg ? signed'(-dvd) : signed'(dvd);
    end
    if (cmd.out_load) begin
      value    <= curr;
      overflow <= ovf;
    end
  end

endmodule

// File: test/associated_laguerre_eval_monitor.sv
module associated_laguerre_eval_monitor import alag_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [DATA_W-1:0]    m_tdata,
  input  logic                 m_tuser,
  output int                   failures,
  output int                   outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              overflow;
  } laguerre_result_t;

  localparam longint ONE      = longint'(1) <<< DEF_FRAC_BITS;
  localparam longint SAT_HIGH = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SAT_LOW  = 64'sh8000_0000_0000_0000;

  laguerre_result_t expected_values[$];

  // Full 128-bit product, arithmetic shift by the fraction width, then
  // clamp to 64 bits.
  function automatic longint scaled_product(input longint a, input longint b, inout bit sat);
    logic signed [127:0] wide_a;
    logic signed [127:0] wide_b;
    logic signed [127:0] full;
    logic signed [127:0] scaled;
    wide_a = a;
    wide_b = b;
    full   = wide_a * wide_b;
    scaled = full >>> DEF_FRAC_BITS;
    if (scaled[127:63] != {65{scaled[63]}}) begin
      sat = 1'b1;
      return full[127] ? SAT_LOW : SAT_HIGH;
    end
    return scaled[63:0];
  endfunction

  function automatic longint clamped_difference(input longint a, input longint b, inout bit sat);
    longint diff;
    diff = a - b;
    if ((a < 0) != (b < 0) && (diff < 0) != (a < 0)) begin
      sat = 1'b1;
      return (a < 0) ? SAT_LOW : SAT_HIGH;
    end
    return diff;
  endfunction

  function automatic laguerre_result_t laguerre_eval(input logic [DEGREE_W-1:0] degree,
                                                     input logic [ORDER_W-1:0] order,
                                                     input logic signed [POINT_W-1:0] point);
    longint x;
    longint older;
    longint newer;
    longint coef_a;
    longint coef_b;
    longint term_a;
    longint term_b;
    longint diff;
    int steps;
    int k;
    bit sat;
    laguerre_result_t r;
    x = point;
    k = order;
    sat = 1'b0;
    steps = degree;
    if (steps > DEF_MAX_DEGREE) begin
      steps = DEF_MAX_DEGREE;
    end
    older = ONE;
    newer = longint'(k + 1) * ONE - x;
    if (steps == 0) begin
      newer = ONE;
    end
    for (int j = 1; j < steps; j++) begin
      coef_a = longint'(2 * j + k + 1) * ONE - x;
      coef_b = longint'(j + k) * ONE;
      term_a = scaled_product(coef_a, newer, sat);
      term_b = scaled_product(coef_b, older, sat);
      diff   = clamped_difference(term_a, term_b, sat);
      older  = newer;
      // Signed division truncates toward zero.
      newer  = diff / longint'(j + 1);
    end
    r.value    = newer;
    r.overflow = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    laguerre_result_t want;
    int fresh;
    fresh = 0;
    if (!rst) begin
      // A result is never ready at the edge where its input is taken, so popping
      // first never matches a result against an item taken at the same edge.
      if (m_tvalid && m_tready) begin
        if (expected_values.size() == 0) begin
          $error("unexpected result: value %0d, overflow %0b", $signed(m_tdata), m_tuser);
          fresh++;
        end else begin
          want = expected_values.pop_front();
          if (m_tdata !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(want.value), $signed(m_tdata));
            fresh++;
          end
          if (m_tuser !== want.overflow) begin
            $error("overflow mismatch: expected %0b, actual %0b", want.overflow, m_tuser);
            fresh++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_values.push_back(laguerre_eval(s_tdata[DEGREE_LSB +: DEGREE_W],
                                                s_tdata[ORDER_LSB +: ORDER_W],
                                                s_tdata[POINT_LSB +: POINT_W]));
      end
      failures    <= failures + fresh;
      outstanding <= expected_values.size();
    end
  end

endmodule

// File: test/associated_laguerre_eval_unit_test.sv
module associated_laguerre_eval_unit_test;
  import alag_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_ITEMS   = 100;
  localparam int LONG_HOLD    = 1500;
  localparam int STALL_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 400;

  localparam logic [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
  localparam logic [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [DATA_W-1:0]    m_tdata;
  logic                 m_tuser;

  int failures;
  int outstanding;
  int stall_cycles = 0;
  int gap_odds = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  always #4 clk = ~clk;

  associated_laguerre_eval_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  associated_laguerre_eval_monitor result_monitor (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // Offers one item, waits for its transfer, then maybe idles for a burst.
  task automatic offer(input logic [DEGREE_W-1:0] degree, input logic [ORDER_W-1:0] order,
                       input logic [POINT_W-1:0] point);
    logic [S_TDATA_W-1:0] word;
    word = '0;
    word[DEGREE_LSB +: DEGREE_W] = degree;
    word[ORDER_LSB +: ORDER_W]   = order;
    word[POINT_LSB +: POINT_W]   = point;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    if (!calm && $urandom_range(1, 100) <= gap_odds) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // The monitor's count is registered, so it is read only after the
  // last transfer has been counted.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [POINT_W-1:0] random_point();
    logic [31:0] r;
    logic [POINT_W-1:0] p;
    r = $urandom;
    case ($urandom_range(0, 9)) inside
      [0:3]: p = {{(POINT_W-28){r[27]}}, r[27:0]};
      [4:5]: p = {{(POINT_W-32){r[31]}}, r};
      6: begin
        p = POINT_W'($urandom_range(0, 40)) << DEF_FRAC_BITS;
        if (r[0]) begin
          p = -p;
        end
      end
      default: p = POINT_W'({$urandom, r});
    endcase
    return p;
  endfunction

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random stall bursts with a stall rate that changes now and then,
  // plus one long hold-off on request.
  initial begin
    int ready_odds;
    int left;
    ready_odds = 0;
    left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_odds = 0;
          1:       ready_odds = 5;
          2:       ready_odds = 25;
          default: ready_odds = 60;
        endcase
        left = 256;
      end
      left--;
      if (hold_request) begin
        m_tready <= 1'b0;
        hold_request <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (!calm && $urandom_range(1, 100) <= ready_odds) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Degree zero and one, extreme orders and points.
    offer(4'd0, 5'd0, '0);
    offer(4'd0, 5'd31, POINT_MIN);
    offer(4'd1, 5'd0, '0);
    offer(4'd1, 5'd31, POINT_MAX);
    offer(4'd1, 5'd31, POINT_MIN);
    offer(4'd1, 5'd0, POINT_MIN);
    // Fractional points, where the division truncates toward zero.
    offer(4'd2, 5'd0, 40'h00_0380_0000);
    offer(4'd2, 5'd3, 40'hFF_FEC0_0000);
    offer(4'd3, 5'd1, 40'h00_0000_0001);
    offer(4'd4, 5'd0, 40'hFF_FFFF_FFFF);
    // Full and high degree, from well inside the range to saturation.
    offer(4'd15, 5'd0, '0);
    offer(4'd15, 5'd31, '0);
    offer(4'd15, 5'd15, 40'h00_0A00_0000);
    offer(4'd8, 5'd5, 40'hFF_EC00_0000);
    offer(4'd15, 5'd0, POINT_MAX);
    offer(4'd15, 5'd31, POINT_MIN);
    offer(4'd15, 5'd0, POINT_MIN);
    offer(4'd12, 5'd31, POINT_MAX);
    offer(4'd15, 5'd31, 40'h80_0000_0001);
    offer(4'd15, 5'd7, 40'h7F_FFFF_FFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_odds = 0;
          1:       gap_odds = 10;
          default: gap_odds = 40;
        endcase
      end
      if (i == 400) begin
        hold_request <= 1'b1;
      end
      if (i == 800) begin
        settle();
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        calm <= 1'b1;
      end
      offer(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)), random_point());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
